// ===== src/stp_pkg.sv =====
// Shared types, constants and field layout tables for the telemetry reply parser.
// No dependencies.
`timescale 1ns / 1ps

package stp_pkg;

    localparam int unsigned STP_BYTE_W     = 8;
    localparam int unsigned STP_IDX_W      = 5;
    localparam int unsigned STP_VALUE_W    = 33;
    localparam int unsigned STP_FIELDS     = 26;
    localparam int unsigned STP_SEL_FIELDS = 22;
    localparam int unsigned STP_ADC_FIRST  = 22;
    localparam int unsigned STP_ADC_LAST   = 25;
    localparam int unsigned STP_MASK_BYTES = 4;
    localparam int unsigned STP_CFG_IDX_W  = 2;
    localparam int unsigned STP_TDATA_W    = 72;
    localparam int unsigned STP_RES_DEPTH  = 4;

    localparam logic [7:0] STP_SEL_CODE_RST = 8'd51;
    localparam logic [7:0] STP_ADC_CODE_RST = 8'd32;

    localparam logic [STP_CFG_IDX_W-1:0] CFG_SEL_CODE = 2'd0;
    localparam logic [STP_CFG_IDX_W-1:0] CFG_ADC_CODE = 2'd1;

    localparam logic KIND_FIELD  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_MASK,
        PH_SEL,
        PH_ADC,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic                          kind;
        logic [STP_IDX_W-1:0]          index;
        logic signed [STP_VALUE_W-1:0] value;
        logic                          accepted;
        logic [STP_FIELDS-1:0]         valid_bits;
        logic                          ends;
    } t_result;

    function automatic logic [2:0] field_bytes(input logic [STP_IDX_W-1:0] idx);
        logic [2:0] n;
        unique case (idx)
            5'd0, 5'd1, 5'd4, 5'd7, 5'd8: n = 3'd2;
            5'd16, 5'd17, 5'd18:          n = 3'd1;
            default:                      n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic field_is_signed(input logic [STP_IDX_W-1:0] idx);
        logic s;
        unique case (idx)
            5'd16, 5'd17, 5'd18, 5'd20, 5'd21: s = 1'b0;
            default:                           s = 1'b1;
        endcase
        return s;
    endfunction

endpackage

// ===== src/selective_telemetry_reply_parser.sv =====
// Each payload byte's result words are written into the result queue at the edge that takes the byte.
// Throughput: one payload byte per cycle; the result queue drains one word per cycle.
// A last byte that also completes a field yields two words; input stalls only when the
// queue holds fewer than two free slots. Synchronous active-low reset clears the parser,
// the kept valid mask and the queue, and loads the reply codes 51 and 32.
`timescale 1ns / 1ps

module selective_telemetry_reply_parser #(
    parameter int unsigned RES_DEPTH = stp_pkg::STP_RES_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [stp_pkg::STP_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] payload_byte
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [4:0] field_index, [37:5] field_value, [38] accepted, [64:39] valid_bits, [71:65] zero
    output logic [stp_pkg::STP_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,  // [0] result_kind
    output logic                              m_axis_tlast
);
    import stp_pkg::*;

    logic [7:0] r_sel_code;
    logic [7:0] r_adc_code;
    logic       accept;
    logic       push0, push1;
    logic       room2;
    t_result    res0, res1, head;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room2;
    assign accept        = s_axis_tvalid && room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_code <= STP_SEL_CODE_RST;
            r_adc_code <= STP_ADC_CODE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEL_CODE: r_sel_code <= i_cfg_data;
                CFG_ADC_CODE: r_adc_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    stp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_sel_code (r_sel_code),
        .i_adc_code (r_adc_code),
        .o_push0    (push0),
        .o_push1    (push1),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    stp_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_res   (head)
    );

    assign m_axis_tdata = {7'd0, head.valid_bits, head.accepted, head.value, head.index};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.ends;

endmodule

// ===== src/stp_core.sv =====
// Byte parser: command, selection mask and field decode, status on the last byte.
// Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic [7:0]             i_sel_code,
    input  logic [7:0]             i_adc_code,
    output logic                   o_push0,
    output logic                   o_push1,
    output stp_pkg::t_result       o_res0,
    output stp_pkg::t_result       o_res1
);
    import stp_pkg::*;

    t_phase                    r_phase, n_phase;
    logic                      r_err, n_err;
    logic [STP_IDX_W-1:0]      r_cur, n_cur;
    logic [2:0]                r_bif, n_bif;
    logic [23:0]               r_acc, n_acc;
    logic [STP_SEL_FIELDS-1:0] r_sel, n_sel;
    logic [STP_FIELDS-1:0]     r_pend, n_pend;
    logic [STP_FIELDS-1:0]     r_kept, n_kept;

    logic [31:0]               acc_sh;
    logic [2:0]                bif_inc;
    logic [5:0]                nxt;
    logic                      ok;
    logic                      field_done;
    t_result                   field_res;
    t_result                   stat_res;

    // Lowest set bit at or above 'from'; bit 5 flags a hit.
    function automatic logic [5:0] first_sel(input logic [STP_SEL_FIELDS-1:0] m,
                                             input logic [STP_IDX_W-1:0] from);
        logic [5:0] r;
        r = '0;
        for (int k = STP_SEL_FIELDS - 1; k >= 0; k--) begin
            if (m[k] && (STP_IDX_W'(k) >= from)) begin
                r = {1'b1, 5'(k)};
            end
        end
        return r;
    endfunction

    function automatic logic signed [STP_VALUE_W-1:0] extend(input logic [31:0] a,
                                                            input logic [STP_IDX_W-1:0] idx);
        logic s;
        logic signed [STP_VALUE_W-1:0] v;
        s = field_is_signed(idx);
        unique case (field_bytes(idx))
            3'd1:    v = {{25{a[7] & s}}, a[7:0]};
            3'd2:    v = {{17{a[15] & s}}, a[15:0]};
            default: v = {a[31] & s, a};
        endcase
        return v;
    endfunction

    assign acc_sh  = {r_acc, i_byte};
    assign bif_inc = r_bif + 3'd1;

    always_comb begin
        n_phase    = r_phase;
        n_err      = r_err;
        n_cur      = r_cur;
        n_bif      = r_bif;
        n_acc      = r_acc;
        n_sel      = r_sel;
        n_pend     = r_pend;
        n_kept     = r_kept;
        nxt        = '0;
        field_done = 1'b0;
        ok         = 1'b0;
        if (!r_err) begin
            unique case (r_phase)
                PH_CMD: begin
                    n_acc = '0;
                    n_bif = '0;
                    if (i_byte == i_sel_code) begin
                        n_phase = PH_MASK;
                    end else if (i_byte == i_adc_code) begin
                        n_phase = PH_ADC;
                        n_cur   = STP_IDX_W'(STP_ADC_FIRST);
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_MASK: begin
                    n_acc = acc_sh[23:0];
                    n_bif = bif_inc;
                    if (bif_inc >= 3'(STP_MASK_BYTES)) begin
                        n_sel = acc_sh[STP_SEL_FIELDS-1:0];
                        n_acc = '0;
                        n_bif = '0;
                        nxt   = first_sel(acc_sh[STP_SEL_FIELDS-1:0], '0);
                        if (nxt[5]) begin
                            n_phase = PH_SEL;
                            n_cur   = nxt[4:0];
                        end else begin
                            n_phase = PH_DONE;
                            n_cur   = '0;
                        end
                    end
                end
                PH_SEL, PH_ADC: begin
                    n_acc = acc_sh[23:0];
                    n_bif = bif_inc;
                    if (bif_inc >= field_bytes(r_cur)) begin
                        field_done = 1'b1;
                        n_pend     = r_pend | (STP_FIELDS'(1) << r_cur);
                        n_acc      = '0;
                        n_bif      = '0;
                        if (r_phase == PH_ADC) begin
                            if (r_cur >= STP_IDX_W'(STP_ADC_LAST)) begin
                                n_phase = PH_DONE;
                                n_cur   = '0;
                            end else begin
                                n_cur = r_cur + 5'd1;
                            end
                        end else begin
                            nxt = first_sel(r_sel, r_cur + 5'd1);
                            if (nxt[5]) begin
                                n_cur = nxt[4:0];
                            end else begin
                                n_phase = PH_DONE;
                                n_cur   = '0;
                            end
                        end
                    end
                end
                default: n_err = 1'b1;
            endcase
        end
        if (i_last) begin
            ok = !n_err && (n_phase == PH_DONE);
            if (ok) begin
                n_kept = r_kept | n_pend;
            end
            n_phase = PH_CMD;
            n_err   = 1'b0;
            n_cur   = '0;
            n_bif   = '0;
            n_acc   = '0;
            n_sel   = '0;
            n_pend  = '0;
        end
    end

    always_comb begin
        field_res            = '0;
        field_res.kind       = KIND_FIELD;
        field_res.index      = r_cur;
        field_res.value      = extend(acc_sh, r_cur);
        stat_res             = '0;
        stat_res.kind        = KIND_STATUS;
        stat_res.accepted    = ok;
        stat_res.valid_bits  = n_kept;
        stat_res.ends        = 1'b1;
        if (field_done) begin
            o_res0 = field_res;
        end else begin
            o_res0 = stat_res;
        end
        o_res1  = stat_res;
        o_push0 = i_accept && (field_done || i_last);
        o_push1 = i_accept && field_done && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_err   <= 1'b0;
            r_cur   <= '0;
            r_bif   <= '0;
            r_acc   <= '0;
            r_sel   <= '0;
            r_pend  <= '0;
            r_kept  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_cur   <= n_cur;
            r_bif   <= n_bif;
            r_acc   <= n_acc;
            r_sel   <= n_sel;
            r_pend  <= n_pend;
            r_kept  <= n_kept;
        end
    end

endmodule

// ===== src/stp_res_fifo.sv =====
// Result queue: takes up to two words a cycle, hands out one.
// Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_res_fifo #(
    parameter int unsigned DEPTH = stp_pkg::STP_RES_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push0,
    input  logic             i_push1,
    input  stp_pkg::t_result i_res0,
    input  stp_pkg::t_result i_res1,
    output logic             o_room2,
    output logic             o_valid,
    input  logic             i_pop,
    output stp_pkg::t_result o_res
);
    import stp_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PTR_W-1:0]   wr1;
    logic [PTR_W-1:0]   wr2;
    logic [PTR_W-1:0]   rd1;
    logic               pop;

    assign wr1     = (r_wr == LAST_SLOT) ? '0 : r_wr + PTR_W'(1);
    assign wr2     = (wr1 == LAST_SLOT) ? '0 : wr1 + PTR_W'(1);
    assign rd1     = (r_rd == LAST_SLOT) ? '0 : r_rd + PTR_W'(1);
    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign o_room2 = (r_cnt <= CNT_W'(DEPTH - 2));

    always_comb begin
        n_wr  = i_push1 ? wr2 : (i_push0 ? wr1 : r_wr);
        n_rd  = pop ? rd1 : r_rd;
        n_cnt = r_cnt + CNT_W'(i_push0) + CNT_W'(i_push1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push1) begin
            r_mem[wr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the telemetry reply parser: streams reply payloads with random
// idling on both sides and checks every field and status word against a built-in decoder.
// Depends on stp_pkg and selective_telemetry_reply_parser.
`timescale 1ns / 1ps

module tb_top;
    import stp_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned PHASE_BYTES = 280;
    localparam logic [STP_CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [STP_CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;
    // field layout: one-byte fields, two-byte fields, unsigned fields (others are 4 bytes, signed)
    localparam logic [STP_FIELDS-1:0] FLD_ONE      = 26'h0070000;
    localparam logic [STP_FIELDS-1:0] FLD_TWO      = 26'h0000193;
    localparam logic [STP_FIELDS-1:0] FLD_UNSIGNED = 26'h0370000;

    typedef enum logic [1:0] {PK_SEL, PK_ADC, PK_NOISE} t_pkt_shape;
    typedef enum logic [1:0] {FL_NONE, FL_CUT, FL_TRAIL} t_flaw;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [STP_CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [7:0]                i_cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;   // [7:0] payload_byte
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // [4:0] field_index, [37:5] field_value, [38] accepted, [64:39] valid_bits, [71:65] zero
    logic [STP_TDATA_W-1:0]    m_axis_tdata;
    logic                      m_axis_tuser;        // [0] result_kind
    logic                      m_axis_tlast;

    selective_telemetry_reply_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // decoder state
    logic [7:0]            sel_code = STP_SEL_CODE_RST;
    logic [7:0]            adc_code = STP_ADC_CODE_RST;
    logic [STP_FIELDS-1:0] kept_mask = '0;
    logic [STP_FIELDS-1:0] pend_mask = '0;
    logic [31:0]           sel_mask = '0;
    t_phase                phase = PH_CMD;
    int unsigned           cur_field = 0;
    int unsigned           byte_cnt = 0;
    logic [31:0]           acc = '0;
    logic                  pkt_err = 1'b0;

    t_payload_word   payload_q[$];
    t_result         due_results[$];
    int unsigned     bytes_queued = 0;
    int unsigned     bytes_taken = 0;
    int unsigned     bad_count = 0;

    function automatic int unsigned field_len(input int unsigned k);
        return FLD_ONE[k] ? 1 : (FLD_TWO[k] ? 2 : 4);
    endfunction

    function automatic int unsigned next_field(input int unsigned from);
        int unsigned k;
        for (k = from; k < STP_SEL_FIELDS; k++)
            if (sel_mask[k]) return k;
        return STP_SEL_FIELDS;
    endfunction

    function automatic logic [STP_VALUE_W-1:0] widen(input logic [31:0] raw,
                                                     input int unsigned k);
        logic s;
        s = !FLD_UNSIGNED[k];
        case (field_len(k))
            1:       return {{25{s & raw[7]}}, raw[7:0]};
            2:       return {{17{s & raw[15]}}, raw[15:0]};
            default: return {s & raw[31], raw};
        endcase
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        t_result r;
        logic    ok;
        if (!pkt_err) begin
            case (phase)
                PH_CMD: begin
                    acc = '0;
                    byte_cnt = 0;
                    if (b == sel_code) begin
                        phase = PH_MASK;
                    end else if (b == adc_code) begin
                        phase = PH_ADC;
                        cur_field = STP_ADC_FIRST;
                    end else begin
                        pkt_err = 1'b1;
                    end
                end
                PH_MASK: begin
                    acc = {acc[23:0], b};
                    byte_cnt++;
                    if (byte_cnt == STP_MASK_BYTES) begin
                        sel_mask = acc;
                        acc = '0;
                        byte_cnt = 0;
                        cur_field = next_field(0);
                        if (cur_field < STP_SEL_FIELDS) begin
                            phase = PH_SEL;
                        end else begin
                            phase = PH_DONE;
                            cur_field = 0;
                        end
                    end
                end
                PH_SEL, PH_ADC: begin
                    acc = {acc[23:0], b};
                    byte_cnt++;
                    if (byte_cnt == field_len(cur_field)) begin
                        r = '0;
                        r.kind = KIND_FIELD;
                        r.index = cur_field[STP_IDX_W-1:0];
                        r.value = widen(acc, cur_field);
                        due_results.push_back(r);
                        pend_mask[cur_field] = 1'b1;
                        acc = '0;
                        byte_cnt = 0;
                        if (phase == PH_ADC) begin
                            if (cur_field == STP_ADC_LAST) begin
                                phase = PH_DONE;
                                cur_field = 0;
                            end else begin
                                cur_field++;
                            end
                        end else begin
                            cur_field = next_field(cur_field + 1);
                            if (cur_field >= STP_SEL_FIELDS) begin
                                phase = PH_DONE;
                                cur_field = 0;
                            end
                        end
                    end
                end
                default: pkt_err = 1'b1;
            endcase
        end
        if (fin) begin
            ok = !pkt_err && phase == PH_DONE;
            if (ok) kept_mask = kept_mask | pend_mask;
            r = '0;
            r.kind = KIND_STATUS;
            r.accepted = ok;
            r.valid_bits = kept_mask;
            r.ends = 1'b1;
            due_results.push_back(r);
            pend_mask = '0;
            sel_mask = '0;
            phase = PH_CMD;
            cur_field = 0;
            byte_cnt = 0;
            acc = '0;
            pkt_err = 1'b0;
        end
    endtask

    task automatic report_bad(input string what, input t_result want, input t_result seen);
        if (bad_count < 10) begin
            $display("%s: expected kind=%0b idx=%0d value=%h acc=%0b valid=%h last=%0b",
                     what, want.kind, want.index, want.value, want.accepted,
                     want.valid_bits, want.ends);
            $display("%s: actual   kind=%0b idx=%0d value=%h acc=%0b valid=%h last=%0b",
                     what, seen.kind, seen.index, seen.value, seen.accepted,
                     seen.valid_bits, seen.ends);
        end
        bad_count++;
    endtask

    // driver: present queued payload words with random gaps
    always @(posedge i_clk) begin : driver
        t_payload_word nxt;
        int unsigned   gap_left = 0;
        bit            tx_burst = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (payload_q.size() != 0) begin
                    nxt = payload_q.pop_front();
                    s_axis_tdata <= nxt.data;
                    s_axis_tlast <= nxt.last;
                    s_axis_tvalid <= 1'b1;
                    gap_left = tx_burst ? 0 : $urandom_range(0, 16);
                    if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall at random and check each result word against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_result     seen;
        t_result     want;
        int unsigned stall_left = 0;
        bit          rx_burst = 1'b0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind = m_axis_tuser;
                seen.index = m_axis_tdata[4:0];
                seen.value = m_axis_tdata[37:5];
                seen.accepted = m_axis_tdata[38];
                seen.valid_bits = m_axis_tdata[64:39];
                seen.ends = m_axis_tlast;
                if (due_results.size() == 0) begin
                    report_bad("unexpected word", '0, seen);
                end else begin
                    want = due_results.pop_front();
                    if (seen.kind !== want.kind || seen.index !== want.index ||
                        seen.value !== want.value || seen.accepted !== want.accepted ||
                        seen.valid_bits !== want.valid_bits || seen.ends !== want.ends)
                        report_bad("word mismatch", want, seen);
                end
                stall_left = rx_burst ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int unsigned quiet = 0;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_payload_word w;
        w.data = b;
        w.last = last;
        payload_q.push_back(w);
        bytes_queued++;
    endtask

    task automatic queue_word(input logic [31:0] w, input logic last);
        queue_byte(w[31:24], 1'b0);
        queue_byte(w[23:16], 1'b0);
        queue_byte(w[15:8], 1'b0);
        queue_byte(w[7:0], last);
    endtask

    task automatic write_reg(input logic [STP_CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SEL_CODE) sel_code = val;
        else if (idx == CFG_ADC_CODE) adc_code = val;
    endtask

    // hold until every queued word is taken and every expected word has come back
    task automatic drain();
        while (bytes_taken != bytes_queued || due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] make_mask();
        logic [21:0] sel;
        logic [9:0]  junk;
        junk = 10'($urandom);
        case ($urandom_range(0, 5))
            0:       sel = '0;
            1:       sel = '1;
            2:       sel = 22'd1 << $urandom_range(0, 21);
            3:       sel = 22'($urandom & $urandom & $urandom);
            default: sel = 22'($urandom & $urandom);
        endcase
        return {junk, sel};
    endfunction

    task automatic send_packet(input t_pkt_shape shape, input t_flaw flaw);
        logic [7:0]  pkt[$];
        logic [31:0] mask;
        int unsigned i;
        int unsigned k;
        int unsigned n_send;
        if (shape == PK_SEL) begin
            mask = make_mask();
            pkt.push_back(sel_code);
            for (i = 0; i < 4; i++) pkt.push_back(mask[31 - 8 * i -: 8]);
            for (k = 0; k < STP_SEL_FIELDS; k++)
                if (mask[k]) repeat (field_len(k)) pkt.push_back(pick_byte());
        end else if (shape == PK_ADC) begin
            pkt.push_back(adc_code);
            repeat (16) pkt.push_back(pick_byte());
        end else begin
            repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
        end
        if (flaw == FL_TRAIL) repeat ($urandom_range(1, 3)) pkt.push_back(pick_byte());
        n_send = pkt.size();
        if (flaw == FL_CUT && n_send > 1) n_send = $urandom_range(1, n_send - 1);
        for (i = 0; i < n_send; i++) queue_byte(pkt[i], i == n_send - 1);
    endtask

    initial begin : stimulus
        int unsigned p;
        int unsigned mark;
        int unsigned roll;
        t_pkt_shape  shape;
        t_flaw       flaw;
        logic [7:0]  s_val;
        logic [7:0]  a_val;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ADC reply with extreme signed values
        queue_byte(adc_code, 1'b0);
        queue_word(32'h8000_0000, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'h0000_0001, 1'b1);
        // empty selection, unused mask bits set
        queue_byte(sel_code, 1'b0);
        queue_word(32'hFFC0_0000, 1'b1);
        // unknown command byte
        queue_byte(8'h00, 1'b1);
        // short mask
        queue_byte(sel_code, 1'b0);
        queue_byte(8'hAB, 1'b1);

        for (p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: begin s_val = 8'd0;   a_val = 8'd255; end
                1: begin s_val = 8'd255; a_val = 8'd0;   end
                2: begin s_val = 8'd7;   a_val = 8'd7;   end
                3: begin s_val = 8'($urandom_range(0, 255)); a_val = 8'($urandom_range(0, 255)); end
                4: begin s_val = STP_ADC_CODE_RST; a_val = STP_SEL_CODE_RST; end
                default: begin s_val = STP_SEL_CODE_RST; a_val = STP_ADC_CODE_RST; end
            endcase
            write_reg(p[0] ? CFG_UNMAPPED_B : CFG_UNMAPPED_A, 8'($urandom_range(0, 255)));
            write_reg(CFG_SEL_CODE, s_val);
            write_reg(CFG_ADC_CODE, a_val);
            mark = bytes_queued;
            while (bytes_queued - mark < PHASE_BYTES) begin
                roll = $urandom_range(0, 99);
                shape = roll < 55 ? PK_SEL : (roll < 80 ? PK_ADC : PK_NOISE);
                roll = $urandom_range(0, 99);
                flaw = roll < 75 ? FL_NONE : (roll < 88 ? FL_CUT : FL_TRAIL);
                if (shape == PK_NOISE) flaw = FL_NONE;
                send_packet(shape, flaw);
                if ($urandom_range(0, 39) == 0) drain();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (bad_count == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
